>>> rtl/core/dcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_pkg: shared types and constants for the dual encoder control panel
// Holds the sample, result, event and configuration types, register index
// codes and the fixed limits of the panel settings.
// ----------------------------------------------------------------------------
package dcp_pkg;

    // width of the free running millisecond timestamp
    localparam int TIME_BITS = 32;

    // configuration port widths
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // register index codes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIN_PRESS  = 3'd0,
        CFG_LONG_PRESS = 3'd1,
        CFG_RESET_FREQ = 3'd2,
        CFG_FREQ_MIN   = 3'd3,
        CFG_FREQ_MAX   = 3'd4,
        CFG_FRAME_MS   = 3'd5,
        CFG_FAN_STEP   = 3'd6
    } cfg_index_t;

    // configuration register reset values
    localparam logic [15:0] MIN_PRESS_RESET  = 16'd50;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd800;
    localparam logic [8:0]  RESET_FREQ_RESET = 9'd60;
    localparam logic [8:0]  FREQ_MIN_RESET   = 9'd2;
    localparam logic [8:0]  FREQ_MAX_RESET   = 9'd500;
    localparam logic [7:0]  FRAME_MS_RESET   = 8'd40;
    localparam logic [6:0]  FAN_STEP_RESET   = 7'd10;

    // panel setting limits and reset values
    localparam logic [8:0] FREQ_INIT   = 9'd60;
    localparam logic [4:0] SPEED_MIN   = 5'd1;
    localparam logic [4:0] SPEED_MAX   = 5'd20;
    localparam logic [4:0] SPEED_INIT  = 5'd5;
    localparam logic [6:0] FAN_MAX     = 7'd100;
    localparam logic [7:0] FAN_WRAP    = 8'd110;
    localparam logic [7:0] FAN_WRAP2   = 8'd220;

    typedef struct packed {
        logic [15:0] min_press_ms;
        logic [15:0] long_press_ms;
        logic [8:0]  reset_freq_half_hz;
        logic [8:0]  freq_min_half_hz;
        logic [8:0]  freq_max_half_hz;
        logic [7:0]  frame_ms_per_speed;
        logic [6:0]  fan_step_percent;
    } cfg_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_ms;
        logic                 enc1_phase_a;
        logic                 enc1_dt;
        logic                 enc1_button;
        logic                 enc2_phase_a;
        logic                 enc2_dt;
        logic                 enc2_button;
    } sample_t;

    typedef struct packed {
        logic [8:0]  freq_half_hz;
        logic        auto_on;
        logic [4:0]  anim_speed_now;
        logic [12:0] frame_period_ms;
        logic [6:0]  fan_level;
        logic        fan_changed;
        logic        show_reset_notice;
        logic        clear_screen;
    } result_t;

    // classified events of one sample
    typedef struct packed {
        logic btn1_long;
        logic btn1_short;
        logic rot1_step;
        logic rot1_down;
        logic rot2_step;
        logic rot2_down;
        logic btn2_press;
    } event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

>>> rtl/core/dcp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_front: sample classifier
// Tracks pin history and press start times, and turns each accepted sample
// into rotation and button events for the back end.
// ----------------------------------------------------------------------------
module dcp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dcp_pkg::cfg_t    cfg,
    input  wire dcp_pkg::sample_t sample,
    input  wire logic             accept,
    output dcp_pkg::event_t       evt
);

    logic                          prev_clk1_reg, prev_clk1_next;
    logic                          prev_clk2_reg, prev_clk2_next;
    logic                          prev_btn1_reg, prev_btn1_next;
    logic                          prev_btn2_reg, prev_btn2_next;
    logic [dcp_pkg::TIME_BITS-1:0] start1_reg, start1_next;
    logic [dcp_pkg::TIME_BITS-1:0] start2_reg, start2_next;

    logic                          btn1_fall, btn1_rise;
    logic                          btn2_fall, btn2_rise;
    logic [dcp_pkg::TIME_BITS-1:0] held1, held2;
    logic                          held1_long, held1_min, held2_min;

    // edge detection and held time
    always_comb
    begin
        btn1_fall  = !sample.enc1_button && prev_btn1_reg;
        btn1_rise  = sample.enc1_button && !prev_btn1_reg;
        btn2_fall  = !sample.enc2_button && prev_btn2_reg;
        btn2_rise  = sample.enc2_button && !prev_btn2_reg;
        held1      = sample.now_ms - start1_reg;
        held2      = sample.now_ms - start2_reg;
        held1_long = held1 >= dcp_pkg::TIME_BITS'(cfg.long_press_ms);
        held1_min  = held1 >= dcp_pkg::TIME_BITS'(cfg.min_press_ms);
        held2_min  = held2 >= dcp_pkg::TIME_BITS'(cfg.min_press_ms);
    end

    // event classification, long press checked first
    always_comb
    begin
        evt.btn1_long  = btn1_rise && held1_long;
        evt.btn1_short = btn1_rise && !held1_long && held1_min;
        evt.rot1_step  = !sample.enc1_phase_a && prev_clk1_reg;
        evt.rot1_down  = sample.enc1_dt;
        evt.rot2_step  = !sample.enc2_phase_a && prev_clk2_reg;
        evt.rot2_down  = sample.enc2_dt;
        evt.btn2_press = btn2_rise && held2_min;
    end

    // history update on each accepted request
    always_comb
    begin
        prev_clk1_next = prev_clk1_reg;
        prev_clk2_next = prev_clk2_reg;
        prev_btn1_next = prev_btn1_reg;
        prev_btn2_next = prev_btn2_reg;
        start1_next    = start1_reg;
        start2_next    = start2_reg;
        if (accept)
        begin
            prev_clk1_next = sample.enc1_phase_a;
            prev_clk2_next = sample.enc2_phase_a;
            prev_btn1_next = sample.enc1_button;
            prev_btn2_next = sample.enc2_button;
            if (btn1_fall)
            begin
                start1_next = sample.now_ms;
            end
            if (btn2_fall)
            begin
                start2_next = sample.now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clk1_reg <= 1'b1;
            prev_clk2_reg <= 1'b1;
            prev_btn1_reg <= 1'b1;
            prev_btn2_reg <= 1'b1;
            start1_reg    <= '0;
            start2_reg    <= '0;
        end
        else
        begin
            prev_clk1_reg <= prev_clk1_next;
            prev_clk2_reg <= prev_clk2_next;
            prev_btn1_reg <= prev_btn1_next;
            prev_btn2_reg <= prev_btn2_next;
            start1_reg    <= start1_next;
            start2_reg    <= start2_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/dcp_evq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_evq: event queue
// Two-entry queue of classified events between the front and the back end.
// ----------------------------------------------------------------------------
module dcp_evq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire dcp_pkg::event_t  wr_data,
    input  wire logic             rd_en,
    output dcp_pkg::event_t       rd_data,
    output dcp_pkg::q_status_t    status
);

    dcp_pkg::event_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_wr, do_rd;

    // status and head entry
    always_comb
    begin
        status.full  = count_reg == 2'd2;
        status.empty = count_reg == 2'd0;
        rd_data      = entry_reg[rd_ptr_reg];
        do_wr        = wr_en && !status.full;
        do_rd        = rd_en && !status.empty;
    end

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/dcp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_back: settings engine
// Applies one event set per cycle, while the result queue has room or is popped,
// to frequency, mode, speed and fan level, and queues the resulting panel state in a two-entry result queue.
// ----------------------------------------------------------------------------
module dcp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dcp_pkg::cfg_t    cfg,
    input  wire logic             evt_valid,
    input  wire dcp_pkg::event_t  evt,
    output logic                  evt_take,
    input  wire logic             pop,
    output dcp_pkg::result_t      result,
    output logic                  empty
);

    logic [8:0]       freq_reg, freq_next;
    logic             auto_reg, auto_next;
    logic [4:0]       speed_reg, speed_next;
    logic [6:0]       fan_reg, fan_next;

    dcp_pkg::result_t outq_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_rd;

    logic [8:0]        freq_a;
    logic              auto_a;
    logic signed [10:0] freq_step;
    logic [7:0]        fan_sum, fan_mod;
    dcp_pkg::result_t  res_new;

    // queue handshake
    always_comb
    begin
        empty    = count_reg == 2'd0;
        do_rd    = pop && !empty;
        evt_take = evt_valid && ((count_reg != 2'd2) || do_rd);
        result   = outq_reg[rd_ptr_reg];
    end

    // button one, then encoder one rotation
    always_comb
    begin
        freq_a = evt.btn1_long ? cfg.reset_freq_half_hz : freq_reg;
        priority if (evt.btn1_long)
        begin
            auto_a = 1'b0;
        end
        else if (evt.btn1_short)
        begin
            auto_a = !auto_reg;
        end
        else
        begin
            auto_a = auto_reg;
        end
        freq_step = $signed({2'b00, freq_a}) + (evt.rot1_down ? -11'sd1 : 11'sd1);
        freq_next = freq_a;
        auto_next = auto_a;
        if (evt.rot1_step)
        begin
            auto_next = 1'b0;
            priority if (freq_step < $signed({2'b00, cfg.freq_min_half_hz}))
            begin
                freq_next = cfg.freq_min_half_hz;
            end
            else if (freq_step > $signed({2'b00, cfg.freq_max_half_hz}))
            begin
                freq_next = cfg.freq_max_half_hz;
            end
            else
            begin
                freq_next = freq_step[8:0];
            end
        end
    end

    // encoder two rotation, speed kept within its limits
    always_comb
    begin
        speed_next = speed_reg;
        if (evt.rot2_step)
        begin
            if (evt.rot2_down)
            begin
                speed_next = (speed_reg <= dcp_pkg::SPEED_MIN) ? dcp_pkg::SPEED_MIN
                                                               : speed_reg - 5'd1;
            end
            else
            begin
                speed_next = (speed_reg >= dcp_pkg::SPEED_MAX) ? dcp_pkg::SPEED_MAX
                                                               : speed_reg + 5'd1;
            end
        end
    end

    // button two, fan level wraps past the top
    always_comb
    begin
        fan_sum = {1'b0, fan_reg} + {1'b0, cfg.fan_step_percent};
        priority if (fan_sum >= dcp_pkg::FAN_WRAP2)
        begin
            fan_mod = fan_sum - dcp_pkg::FAN_WRAP2;
        end
        else if (fan_sum >= dcp_pkg::FAN_WRAP)
        begin
            fan_mod = fan_sum - dcp_pkg::FAN_WRAP;
        end
        else
        begin
            fan_mod = fan_sum;
        end
        fan_next = fan_reg;
        if (evt.btn2_press)
        begin
            fan_next = (fan_mod > {1'b0, dcp_pkg::FAN_MAX}) ? dcp_pkg::FAN_MAX
                                                             : fan_mod[6:0];
        end
    end

    // result assembly
    always_comb
    begin
        res_new.freq_half_hz      = freq_next;
        res_new.auto_on           = auto_next;
        res_new.anim_speed_now    = speed_next;
        res_new.frame_period_ms   = 13'(speed_next * cfg.frame_ms_per_speed);
        res_new.fan_level         = fan_next;
        res_new.fan_changed       = evt.btn2_press;
        res_new.show_reset_notice = evt.btn1_long;
        res_new.clear_screen      = evt.btn1_short;
    end

    // result queue pointers
    always_comb
    begin
        wr_ptr_next = evt_take ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(evt_take) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg   <= dcp_pkg::FREQ_INIT;
            auto_reg   <= 1'b1;
            speed_reg  <= dcp_pkg::SPEED_INIT;
            fan_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (evt_take)
            begin
                freq_reg  <= freq_next;
                auto_reg  <= auto_next;
                speed_reg <= speed_next;
                fan_reg   <= fan_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            outq_reg[wr_ptr_reg] <= res_new;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/dual_encoder_control_panel_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_encoder_control_panel_top: two rotary encoders with button handling
// Path: the front classifies each accepted request into the event queue, and
// the back end computes its result into the result queue read at the ports.
// Throughput: one sample per cycle while the result queue has room or is popped.
// Reset: asynchronous, clears pin history, settings and both queues at once.
// ----------------------------------------------------------------------------
module dual_encoder_control_panel_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire dcp_pkg::sample_t                     sample,
    input  wire logic                                 push,
    output logic                                      full,
    output dcp_pkg::result_t                          result,
    output logic                                      empty,
    input  wire logic                                 pop,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [dcp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [dcp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    dcp_pkg::cfg_t      cfg_reg, cfg_next;
    dcp_pkg::event_t    evt_in, evt_head;
    dcp_pkg::q_status_t evq_status;
    logic               accept;
    logic               evt_take;

    // configuration register file
    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_next  = cfg_reg;
        if (cfg_valid)
        begin
            unique case (dcp_pkg::cfg_index_t'(cfg_index))
                dcp_pkg::CFG_MIN_PRESS:  cfg_next.min_press_ms       = cfg_data;
                dcp_pkg::CFG_LONG_PRESS: cfg_next.long_press_ms      = cfg_data;
                dcp_pkg::CFG_RESET_FREQ: cfg_next.reset_freq_half_hz = cfg_data[8:0];
                dcp_pkg::CFG_FREQ_MIN:   cfg_next.freq_min_half_hz   = cfg_data[8:0];
                dcp_pkg::CFG_FREQ_MAX:   cfg_next.freq_max_half_hz   = cfg_data[8:0];
                dcp_pkg::CFG_FRAME_MS:   cfg_next.frame_ms_per_speed = cfg_data[7:0];
                dcp_pkg::CFG_FAN_STEP:   cfg_next.fan_step_percent   = cfg_data[6:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_press_ms       <= dcp_pkg::MIN_PRESS_RESET;
            cfg_reg.long_press_ms      <= dcp_pkg::LONG_PRESS_RESET;
            cfg_reg.reset_freq_half_hz <= dcp_pkg::RESET_FREQ_RESET;
            cfg_reg.freq_min_half_hz   <= dcp_pkg::FREQ_MIN_RESET;
            cfg_reg.freq_max_half_hz   <= dcp_pkg::FREQ_MAX_RESET;
            cfg_reg.frame_ms_per_speed <= dcp_pkg::FRAME_MS_RESET;
            cfg_reg.fan_step_percent   <= dcp_pkg::FAN_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input side handshake
    always_comb
    begin
        full   = evq_status.full;
        accept = push && !evq_status.full;
    end

    // front: classify samples
    dcp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .sample (sample),
        .accept (accept),
        .evt    (evt_in)
    );

    // event queue between front and back
    dcp_evq u_evq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (evt_in),
        .rd_en   (evt_take),
        .rd_data (evt_head),
        .status  (evq_status)
    );

    // back: apply events and queue results
    dcp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .evt_valid (!evq_status.empty),
        .evt       (evt_head),
        .evt_take  (evt_take),
        .pop       (pop),
        .result    (result),
        .empty     (empty)
    );

    // fan level never shown above its top
    a_fan_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.fan_level <= dcp_pkg::FAN_MAX)
        else $error("fan level above limit");

    // animation speed stays within its limits
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.anim_speed_now >= dcp_pkg::SPEED_MIN &&
                    result.anim_speed_now <= dcp_pkg::SPEED_MAX))
        else $error("animation speed out of range");

    // frame period tracks speed and the current scale
    a_frame_period: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.frame_period_ms ==
                   13'(result.anim_speed_now * cfg_reg.frame_ms_per_speed))
        else $error("frame period mismatch");

endmodule
`default_nettype wire

>>> verif/dual_encoder_control_panel_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_encoder_control_panel_top_test: self-checking bench for the panel top
// Drives poll samples through the request queue with random bursts and gaps.
// The receiver stalls on its own pattern. A scoreboard predicts every
// readout and compares it field by field. Directed gestures come first:
// knob steps, short and long presses, timestamp wrap and a long press
// threshold below the minimum press. Random phases follow, each with new
// register settings that include the extremes.
// ----------------------------------------------------------------------------
module dual_encoder_control_panel_top_test;
    import dcp_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;

    // predicts panel readouts from accepted samples
    class panel_scoreboard;
        cfg_t                 regs;
        logic                 last_clk1;
        logic                 last_clk2;
        logic                 last_btn1;
        logic                 last_btn2;
        logic [TIME_BITS-1:0] press_t1;
        logic [TIME_BITS-1:0] press_t2;
        logic [8:0]           freq;
        logic                 auto_mode;
        logic [4:0]           speed;
        logic [6:0]           fan;
        result_t              pending_readouts[$];
        int                   mismatches;

        function new();
            regs.min_press_ms       = MIN_PRESS_RESET;
            regs.long_press_ms      = LONG_PRESS_RESET;
            regs.reset_freq_half_hz = RESET_FREQ_RESET;
            regs.freq_min_half_hz   = FREQ_MIN_RESET;
            regs.freq_max_half_hz   = FREQ_MAX_RESET;
            regs.frame_ms_per_speed = FRAME_MS_RESET;
            regs.fan_step_percent   = FAN_STEP_RESET;
            last_clk1  = 1'b1;
            last_clk2  = 1'b1;
            last_btn1  = 1'b1;
            last_btn2  = 1'b1;
            press_t1   = '0;
            press_t2   = '0;
            freq       = FREQ_INIT;
            auto_mode  = 1'b1;
            speed      = SPEED_INIT;
            fan        = '0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] data);
            case (idx)
                CFG_MIN_PRESS:  regs.min_press_ms       = data;
                CFG_LONG_PRESS: regs.long_press_ms      = data;
                CFG_RESET_FREQ: regs.reset_freq_half_hz = data[8:0];
                CFG_FREQ_MIN:   regs.freq_min_half_hz   = data[8:0];
                CFG_FREQ_MAX:   regs.freq_max_half_hz   = data[8:0];
                CFG_FRAME_MS:   regs.frame_ms_per_speed = data[7:0];
                CFG_FAN_STEP:   regs.fan_step_percent   = data[6:0];
                default: ;
            endcase
        endfunction

        // button one, knob one, knob two, button two, in that order
        function void apply_sample(sample_t s);
            logic [TIME_BITS-1:0] held;
            int                   lo;
            int                   hi;
            int                   level;
            result_t              r;
            r = '0;

            // button one release: long press wins over short press
            if (!s.enc1_button && last_btn1)
                press_t1 = s.now_ms;
            if (s.enc1_button && !last_btn1)
            begin
                held = s.now_ms - press_t1;
                if (held >= regs.long_press_ms)
                begin
                    freq                = regs.reset_freq_half_hz;
                    auto_mode           = 1'b0;
                    r.show_reset_notice = 1'b1;
                end
                else if (held >= regs.min_press_ms)
                begin
                    auto_mode      = !auto_mode;
                    r.clear_screen = 1'b1;
                end
            end
            last_btn1 = s.enc1_button;

            // knob one: raise to min first, else lower to max
            if (!s.enc1_phase_a && last_clk1)
            begin
                lo    = int'(regs.freq_min_half_hz);
                hi    = int'(regs.freq_max_half_hz);
                level = int'(freq) + (s.enc1_dt ? -1 : 1);
                if (level < lo)
                    level = lo;
                else if (level > hi)
                    level = hi;
                freq      = level[8:0];
                auto_mode = 1'b0;
            end
            last_clk1 = s.enc1_phase_a;

            // knob two: data high slows down
            if (!s.enc2_phase_a && last_clk2)
            begin
                level = int'(speed) + (s.enc2_dt ? -1 : 1);
                if (level < int'(SPEED_MIN))
                    level = int'(SPEED_MIN);
                else if (level > int'(SPEED_MAX))
                    level = int'(SPEED_MAX);
                speed = level[4:0];
            end
            last_clk2 = s.enc2_phase_a;

            // button two release steps the fan with wrap
            if (!s.enc2_button && last_btn2)
                press_t2 = s.now_ms;
            if (s.enc2_button && !last_btn2)
            begin
                held = s.now_ms - press_t2;
                if (held >= regs.min_press_ms)
                begin
                    level = (int'(fan) + int'(regs.fan_step_percent)) % int'(FAN_WRAP);
                    if (level > int'(FAN_MAX))
                        level = int'(FAN_MAX);
                    fan           = level[6:0];
                    r.fan_changed = 1'b1;
                end
            end
            last_btn2 = s.enc2_button;

            r.freq_half_hz    = freq;
            r.auto_on         = auto_mode;
            r.anim_speed_now  = speed;
            r.frame_period_ms = 13'(speed * regs.frame_ms_per_speed);
            r.fan_level       = fan;
            pending_readouts.push_back(r);
        endfunction

        function void note_mismatch(string what, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_readouts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("readout with nothing pending: expected none, got %h", got);
                return;
            end
            want = pending_readouts.pop_front();
            if (got.freq_half_hz !== want.freq_half_hz)
                note_mismatch("freq_half_hz", want.freq_half_hz, got.freq_half_hz);
            if (got.auto_on !== want.auto_on)
                note_mismatch("auto_on", want.auto_on, got.auto_on);
            if (got.anim_speed_now !== want.anim_speed_now)
                note_mismatch("anim_speed_now", want.anim_speed_now, got.anim_speed_now);
            if (got.frame_period_ms !== want.frame_period_ms)
                note_mismatch("frame_period_ms", want.frame_period_ms, got.frame_period_ms);
            if (got.fan_level !== want.fan_level)
                note_mismatch("fan_level", want.fan_level, got.fan_level);
            if (got.fan_changed !== want.fan_changed)
                note_mismatch("fan_changed", want.fan_changed, got.fan_changed);
            if (got.show_reset_notice !== want.show_reset_notice)
                note_mismatch("show_reset_notice", want.show_reset_notice,
                              got.show_reset_notice);
            if (got.clear_screen !== want.clear_screen)
                note_mismatch("clear_screen", want.clear_screen, got.clear_screen);
        endfunction
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    sample_t                  sample    = '0;
    logic                     push      = 1'b0;
    logic                     full;
    result_t                  result;
    logic                     empty;
    logic                     pop       = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    panel_scoreboard      sb;
    sample_t              last_sent  = '0;
    logic [TIME_BITS-1:0] clock_ms   = '0;
    logic [TIME_BITS-1:0] press1_ms  = '0;
    logic [TIME_BITS-1:0] press2_ms  = '0;
    int                   burst_left = 0;
    int                   cycles     = 0;
    int                   pop_mode   = 0;
    int                   pop_count  = 0;
    logic [7:0]           pop_bits   = '1;

    dual_encoder_control_panel_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .push      (push),
        .full      (full),
        .result    (result),
        .empty     (empty),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // readout side: check accepted readouts, stall on a changing pattern
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
        if (pop_count % 128 == 0)
        begin
            pop_mode = $urandom_range(0, 3);
            pop_bits = 8'($urandom);
        end
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= pop_bits[pop_count % 8];
            default: pop <= ($urandom_range(0, 15) == 0);
        endcase
        pop_count++;
    end

    // one sample request, sent in bursts with random gaps
    task automatic send_sample(input sample_t s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample <= s;
        push   <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.apply_sample(s);
        if (!s.enc1_button && last_sent.enc1_button)
            press1_ms = s.now_ms;
        if (!s.enc2_button && last_sent.enc2_button)
            press2_ms = s.now_ms;
        clock_ms  = s.now_ms;
        last_sent = s;
    endtask

    // pins in order clk1 dt1 button1 clk2 dt2 button2
    task automatic drive(input logic [TIME_BITS-1:0] t, input logic [5:0] pins);
        sample_t s;
        s.now_ms = t;
        {s.enc1_phase_a, s.enc1_dt, s.enc1_button,
         s.enc2_phase_a, s.enc2_dt, s.enc2_button} = pins;
        send_sample(s);
    endtask

    // stop sending and wait until every readout is back
    task automatic drain();
        if (push)
            push <= 1'b0;
        burst_left = 0;
        while (sb.pending_readouts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic write_config(input cfg_t c);
        write_reg(CFG_MIN_PRESS, c.min_press_ms);
        write_reg(CFG_LONG_PRESS, c.long_press_ms);
        write_reg(CFG_RESET_FREQ, 16'(c.reset_freq_half_hz));
        write_reg(CFG_FREQ_MIN, 16'(c.freq_min_half_hz));
        write_reg(CFG_FREQ_MAX, 16'(c.freq_max_half_hz));
        write_reg(CFG_FRAME_MS, 16'(c.frame_ms_per_speed));
        write_reg(CFG_FAN_STEP, 16'(c.fan_step_percent));
        cfg_valid <= 1'b0;
    endtask

    // settings for one random phase: extremes first, then mixed values
    function automatic cfg_t phase_settings(input int phase);
        cfg_t c;
        int   hi;
        c.min_press_ms       = 16'($urandom_range(0, 200));
        c.long_press_ms      = 16'($urandom_range(0, 2000));
        c.reset_freq_half_hz = 9'($urandom_range(0, 511));
        c.freq_min_half_hz   = 9'($urandom_range(0, 511));
        hi = int'(c.freq_min_half_hz) + $urandom_range(0, 60);
        c.freq_max_half_hz   = (hi > 511) ? 9'd511 : hi[8:0];
        c.frame_ms_per_speed = 8'($urandom_range(0, 255));
        c.fan_step_percent   = 7'($urandom_range(1, 100));
        case (phase)
            0:
            begin
                c = '0;
                c.fan_step_percent = 7'd1;
            end
            1:
            begin
                c.min_press_ms       = 16'hFFFF;
                c.long_press_ms      = 16'hFFFF;
                c.reset_freq_half_hz = 9'd511;
                c.freq_min_half_hz   = 9'd511;
                c.freq_max_half_hz   = 9'd511;
                c.frame_ms_per_speed = 8'd255;
                c.fan_step_percent   = 7'd100;
            end
            2:
            begin
                // clamp limits crossed
                c.freq_min_half_hz = 9'($urandom_range(256, 511));
                c.freq_max_half_hz = 9'($urandom_range(0, 255));
            end
            default: ;
        endcase
        return c;
    endfunction

    // held time around the press thresholds, sometimes anything
    function automatic logic [TIME_BITS-1:0] pick_hold();
        logic [TIME_BITS-1:0] lo_ms;
        logic [TIME_BITS-1:0] hi_ms;
        lo_ms = TIME_BITS'(sb.regs.min_press_ms);
        hi_ms = TIME_BITS'(sb.regs.long_press_ms);
        case ($urandom_range(0, 6))
            0:       return lo_ms - 1;
            1:       return lo_ms;
            2:       return hi_ms - 1;
            3:       return hi_ms;
            4:       return $urandom_range(0, lo_ms);
            5:       return $urandom_range(0, hi_ms + 200);
            default: return $urandom;
        endcase
    endfunction

    // knob turns and button gestures with random content, some noise
    task automatic send_random(input int count);
        sample_t s;
        repeat (count)
        begin
            s = last_sent;
            if ($urandom_range(0, 9) == 0)
            begin
                s.now_ms = $urandom;
                {s.enc1_phase_a, s.enc1_dt, s.enc1_button,
                 s.enc2_phase_a, s.enc2_dt, s.enc2_button} = 6'($urandom);
            end
            else
            begin
                clock_ms = clock_ms + $urandom_range(0, 40);
                if ($urandom_range(0, 1))
                    s.enc1_phase_a = !s.enc1_phase_a;
                s.enc1_dt = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 1))
                    s.enc2_phase_a = !s.enc2_phase_a;
                s.enc2_dt = 1'($urandom_range(0, 1));
                if (s.enc1_button)
                    s.enc1_button = ($urandom_range(0, 7) != 0);
                else if ($urandom_range(0, 3) == 0)
                begin
                    s.enc1_button = 1'b1;
                    clock_ms = press1_ms + pick_hold();
                end
                if (s.enc2_button)
                    s.enc2_button = ($urandom_range(0, 7) != 0);
                else if ($urandom_range(0, 3) == 0)
                begin
                    s.enc2_button = 1'b1;
                    clock_ms = press2_ms + pick_hold();
                end
                s.now_ms = clock_ms;
            end
            send_sample(s);
        end
    endtask

    // main sequence
    initial
    begin
        cfg_t c;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values written back explicitly
        c = phase_settings(3);
        c.min_press_ms       = MIN_PRESS_RESET;
        c.long_press_ms      = LONG_PRESS_RESET;
        c.reset_freq_half_hz = RESET_FREQ_RESET;
        c.freq_min_half_hz   = FREQ_MIN_RESET;
        c.freq_max_half_hz   = FREQ_MAX_RESET;
        c.frame_ms_per_speed = FRAME_MS_RESET;
        c.fan_step_percent   = FAN_STEP_RESET;
        write_config(c);

        // knob steps both ways
        drive(32'd0,    6'b111111);
        drive(32'd5,    6'b001111);
        drive(32'd6,    6'b101111);
        drive(32'd7,    6'b011111);
        drive(32'd8,    6'b111011);
        drive(32'd9,    6'b111101);
        drive(32'd10,   6'b111001);
        // long press, too short, exact minimum
        drive(32'd100,  6'b110101);
        drive(32'd900,  6'b111101);
        drive(32'd1000, 6'b110101);
        drive(32'd1049, 6'b111101);
        drive(32'd2000, 6'b110101);
        drive(32'd2050, 6'b111101);
        // fan button: too short, then counted
        drive(32'd3000, 6'b111100);
        drive(32'd3049, 6'b111101);
        drive(32'd3100, 6'b111100);
        drive(32'd3150, 6'b111101);
        // long press across timestamp wrap
        drive(32'hFFFF_FF00, 6'b110101);
        drive(32'h0000_0300, 6'b111101);
        // everything falls at once, then rises
        drive(32'hFFFF_FFFF, 6'b000000);
        drive(32'h0000_0040, 6'b111111);

        // long press threshold below minimum press, fan step of zero
        drain();
        c.min_press_ms     = 16'd100;
        c.long_press_ms    = 16'd30;
        c.fan_step_percent = 7'd0;
        write_config(c);
        drive(32'd5000, 6'b110110);
        drive(32'd5040, 6'b111111);
        drive(32'd6000, 6'b111110);
        drive(32'd6100, 6'b111111);

        // random phases
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            write_config(phase_settings(phase));
            send_random(PHASE_ITEMS);
        end

        drain();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_readouts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
